// ----- design/llcc_pkg.sv -----
// ----------------------------------------------------------------------------
// llcc_pkg
// Shared types and constants of the laser line column centroid block.
// ----------------------------------------------------------------------------
package llcc_pkg;

  // Field widths.
  localparam int unsigned LLCC_PIX_W  = 8;
  localparam int unsigned LLCC_WSUM_W = 28;
  localparam int unsigned LLCC_DSUM_W = 18;
  localparam int unsigned LLCC_CENT_W = 19;
  localparam int unsigned LLCC_FRAC_W = 8;

  // Defaults and fixed values.
  localparam int unsigned           LLCC_MAX_ROWS    = 1024;
  localparam int unsigned           LLCC_QUEUE_DEPTH = 2;
  localparam logic [LLCC_PIX_W-1:0] LLCC_LEVEL_RESET = 8'd150;

  // Centroid of 1.0 in Q8, reported when no pixel passed the threshold.
  localparam logic [LLCC_CENT_W-1:0] LLCC_CENT_ONE = 19'd256;
  // Largest centroid code; larger quotients clamp here.
  localparam logic [LLCC_CENT_W-1:0] LLCC_CENT_MAX = {LLCC_CENT_W{1'b1}};

  // Width of the divider step counter.
  localparam int unsigned LLCC_STEP_W = $clog2(LLCC_CENT_W + 1);

  // Column sums handed from the front to the divider.
  typedef struct packed {
    logic [LLCC_WSUM_W-1:0] wsum;
    logic [LLCC_DSUM_W-1:0] dsum;
  } llcc_sums_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } llcc_qstat_t;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } llcc_state_e;

endpackage

// ----- design/llcc_front.sv -----
// ----------------------------------------------------------------------------
// llcc_front
// Accepts pixels, applies the threshold and accumulates the two column sums.
// ----------------------------------------------------------------------------
module llcc_front
  import llcc_pkg::*;
#(
  parameter int unsigned MaxRows = LLCC_MAX_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [LLCC_PIX_W-1:0] pixel_value_i,
  input  logic                  last_in_column_i,
  // Threshold register write.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [LLCC_PIX_W-1:0] level_threshold_i,
  // Queue side.
  input  llcc_qstat_t           qstat_i,
  output logic                  push_o,
  output llcc_sums_t            push_data_o
);

  localparam int unsigned RowW  = $clog2(MaxRows + 1);
  localparam int unsigned ProdW = RowW + LLCC_PIX_W;

  logic [LLCC_PIX_W-1:0]  level_q;
  logic [RowW-1:0]        row_q, row_d;
  logic [LLCC_WSUM_W-1:0] wsum_q, wsum_d, wsum_new;
  logic [LLCC_DSUM_W-1:0] dsum_q, dsum_d, dsum_new;
  logic                   accept;
  logic                   counted;
  logic [ProdW-1:0]       prod;
  logic [LLCC_WSUM_W:0]   wsum_ext;
  logic [LLCC_DSUM_W:0]   dsum_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = qstat_i.full;
  assign accept      = in_valid_i && !in_stall_o;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LLCC_LEVEL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      level_q <= level_threshold_i;
    end
  end

  // Row number of the current pixel, saturating at the row limit.
  always_comb begin
    if (row_q < RowW'(MaxRows)) begin
      row_d = row_q + RowW'(1);
    end else begin
      row_d = row_q;
    end
  end

  // Weighted and plain sums with saturation.
  always_comb begin
    counted  = pixel_value_i > level_q;
    prod     = ProdW'(row_d) * ProdW'(pixel_value_i);
    wsum_ext = {1'b0, wsum_q} + (LLCC_WSUM_W + 1)'(prod);
    dsum_ext = {1'b0, dsum_q} + (LLCC_DSUM_W + 1)'(pixel_value_i);
    if (!counted) begin
      wsum_new = wsum_q;
      dsum_new = dsum_q;
    end else begin
      wsum_new = wsum_ext[LLCC_WSUM_W] ? {LLCC_WSUM_W{1'b1}} : wsum_ext[LLCC_WSUM_W-1:0];
      dsum_new = dsum_ext[LLCC_DSUM_W] ? {LLCC_DSUM_W{1'b1}} : dsum_ext[LLCC_DSUM_W-1:0];
    end
  end

  // The last pixel closes the column: push its sums and start over.
  assign push_o           = accept && last_in_column_i;
  assign push_data_o.wsum = wsum_new;
  assign push_data_o.dsum = dsum_new;

  always_comb begin
    wsum_d = wsum_new;
    dsum_d = dsum_new;
    if (last_in_column_i) begin
      wsum_d = '0;
      dsum_d = '0;
    end
  end

  // Column state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      wsum_q <= '0;
      dsum_q <= '0;
    end else if (accept) begin
      row_q  <= last_in_column_i ? '0 : row_d;
      wsum_q <= wsum_d;
      dsum_q <= dsum_d;
    end
  end

endmodule

// ----- design/llcc_queue.sv -----
// ----------------------------------------------------------------------------
// llcc_queue
// Short queue of column sums between the pixel front and the divider.
// ----------------------------------------------------------------------------
module llcc_queue
  import llcc_pkg::*;
#(
  parameter int unsigned Depth = LLCC_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  llcc_sums_t  push_data_i,
  input  logic        pop_i,
  output llcc_sums_t  pop_data_o,
  output llcc_qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  llcc_sums_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign qstat_o.full  = count_q == CntW'(Depth);
  assign qstat_o.empty = count_q == '0;
  assign pop_data_o    = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // A request never enters a full queue, and none leaves an empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !qstat_o.full)
    else $error("llcc_queue: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !qstat_o.empty)
    else $error("llcc_queue: pop from empty queue");

endmodule

// ----- design/llcc_divider.sv -----
// ----------------------------------------------------------------------------
// llcc_divider
// Rounded centroid division, one quotient bit per cycle, with output register.
// ----------------------------------------------------------------------------
module llcc_divider
  import llcc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Queue side.
  input  llcc_qstat_t            qstat_i,
  input  llcc_sums_t             pop_data_i,
  output logic                   pop_o,
  // Result channel.
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LLCC_CENT_W-1:0] centroid_q8_o,
  output logic                   line_found_o
);

  localparam int unsigned NumW = LLCC_WSUM_W + LLCC_FRAC_W + 1;

  llcc_state_e            state_q, state_d;
  logic [LLCC_WSUM_W-1:0] wsum_q;
  logic [LLCC_DSUM_W-1:0] dsum_q;
  logic [LLCC_DSUM_W-1:0] rem_q;
  logic [LLCC_CENT_W-1:0] quo_q;
  logic [LLCC_STEP_W-1:0] cnt_q;
  logic                   found_q;
  logic                   out_valid_q;
  logic [LLCC_CENT_W-1:0] out_cent_q;
  logic                   out_found_q;

  logic [NumW-1:0]        numer;
  logic                   ovf;
  logic [LLCC_DSUM_W:0]   trial;
  logic [LLCC_DSUM_W:0]   diff;
  logic                   ge;
  logic                   out_free;

  // Rounded numerator and the clamp test: quotient too big iff numer >= dsum * 2^19.
  always_comb begin
    numer = NumW'({wsum_q, {LLCC_FRAC_W{1'b0}}}) + NumW'(dsum_q >> 1);
    ovf   = numer >= NumW'({dsum_q, {LLCC_CENT_W{1'b0}}});
  end

  // One restoring division step.
  always_comb begin
    trial = {rem_q, quo_q[LLCC_CENT_W-1]};
    ge    = trial >= {1'b0, dsum_q};
    diff  = trial - {1'b0, dsum_q};
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and queue pop.
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (dsum_q == '0 || ovf) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == LLCC_STEP_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Divider datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        wsum_q <= pop_data_i.wsum;
        dsum_q <= pop_data_i.dsum;
      end
      ST_CHECK: begin
        found_q <= dsum_q != '0;
        rem_q   <= numer[NumW-1 -: LLCC_DSUM_W];
        cnt_q   <= LLCC_STEP_W'(LLCC_CENT_W);
        if (dsum_q == '0) begin
          quo_q <= LLCC_CENT_ONE;
        end else if (ovf) begin
          quo_q <= LLCC_CENT_MAX;
        end else begin
          quo_q <= numer[LLCC_CENT_W-1:0];
        end
      end
      ST_DIV: begin
        rem_q <= ge ? diff[LLCC_DSUM_W-1:0] : trial[LLCC_DSUM_W-1:0];
        quo_q <= {quo_q[LLCC_CENT_W-2:0], ge};
        cnt_q <= cnt_q - LLCC_STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one result while the next column is divided.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_cent_q  <= quo_q;
      out_found_q <= found_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign centroid_q8_o = out_cent_q;
  assign line_found_o  = out_found_q;

  // The partial remainder always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < dsum_q)
    else $error("llcc_divider: partial remainder not below divisor");
  // An empty column reports exactly row 1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_found_o |-> centroid_q8_o == LLCC_CENT_ONE)
    else $error("llcc_divider: empty column with wrong centroid");
  // Rows are 1-based, so no centroid below row 1.0 is possible.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> centroid_q8_o >= LLCC_CENT_ONE)
    else $error("llcc_divider: centroid below row 1.0");

endmodule

// ----- design/laser_line_column_centroid.sv -----
// ----------------------------------------------------------------------------
// laser_line_column_centroid
// Center of gravity of a laser line in one image column, in Q8 rows.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock, top row first, with last_in_column_i set on
// the bottom pixel. Pixels above level_threshold add row * value and value into two
// saturating sums; the last pixel pushes both sums into a two-entry queue and
// clears the column. A serial divider takes one column at a time from the queue
// and steps through pop, a clamp check, the quotient bits (skipped when the check
// settles the result) and hand-off to the output register. The pixel channel
// stalls while the queue is full, as when columns come faster than the divider
// finishes them; the result leaves through an output register that holds while
// the next column is divided.
// ----------------------------------------------------------------------------
module laser_line_column_centroid
  import llcc_pkg::*;
#(
  parameter int unsigned MaxRows = LLCC_MAX_ROWS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Pixel channel.
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [LLCC_PIX_W-1:0]  pixel_value_i,
  input  logic                   last_in_column_i,
  // Threshold register write.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LLCC_PIX_W-1:0]  level_threshold_i,
  // Result channel.
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LLCC_CENT_W-1:0] centroid_q8_o,
  output logic                   line_found_o
);

  llcc_qstat_t qstat;
  logic        push;
  logic        pop;
  llcc_sums_t  push_data;
  llcc_sums_t  pop_data;

  // Pixel front: threshold and column sums.
  llcc_front #(
    .MaxRows(MaxRows)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_value_i    (pixel_value_i),
    .last_in_column_i (last_in_column_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .level_threshold_i(level_threshold_i),
    .qstat_i          (qstat),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  // Column queue.
  llcc_queue #(
    .Depth(LLCC_QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .qstat_o    (qstat)
  );

  // Serial divider and output register.
  llcc_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qstat_i      (qstat),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .centroid_q8_o(centroid_q8_o),
    .line_found_o (line_found_o)
  );

endmodule
